// ----- hw/rtl/orb_pkg.sv -----
//------------------------------------------------------------------------------
// orb_pkg
// Shared types and constants for the overwriting ring buffer.
//------------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CAP_W   = 7;
    localparam int VALUE_W = 32;
    localparam int OUT_W   = 32;
    localparam int OPC_W   = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [OPC_W-1:0] OPC_APPEND = 2'd0;
    localparam logic [OPC_W-1:0] OPC_REMOVE = 2'd1;
    localparam logic [OPC_W-1:0] OPC_LIST   = 2'd2;
    localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_REMOVE,
        OP_LIST,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/orb_front.sv -----
//------------------------------------------------------------------------------
// orb_front
// Accepts command beats and classifies the operation code for the back end.
//------------------------------------------------------------------------------
`default_nettype none

module orb_front
    import orb_pkg::*;
(
    input  wire logic               start,
    input  wire logic [OPC_W-1:0]   i_operation,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_q_full,
    output logic                    busy,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    t_op op_class;

    always_comb begin
        unique case (i_operation)
            OPC_APPEND: op_class = OP_APPEND;
            OPC_REMOVE: op_class = OP_REMOVE;
            OPC_LIST:   op_class = OP_LIST;
            OPC_UNUSED: op_class = OP_NOP;
            default:    op_class = OP_NOP;
        endcase
    end

    assign busy        = i_q_full;
    assign o_push      = start && !i_q_full;
    assign o_cmd.op    = op_class;
    assign o_cmd.value = i_value;

endmodule

`default_nettype wire

// ----- hw/rtl/orb_cmd_queue.sv -----
//------------------------------------------------------------------------------
// orb_cmd_queue
// Two-entry command queue between the front and the back end.
//------------------------------------------------------------------------------
`default_nettype none

module orb_cmd_queue
    import orb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_full,
    output t_cmd      o_cmd
);

    t_cmd                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/orb_back.sv -----
//------------------------------------------------------------------------------
// orb_back
// Executes queued commands on the ring state and entry memory, and sequences
// list read-out one entry per cycle while no configuration write is in progress.
//------------------------------------------------------------------------------
`default_nettype none

module orb_back
    import orb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CAP_W-1:0] i_cfg_wr_data,
    input  wire logic             i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_result_valid,
    output logic [OUT_W-1:0]      o_data,
    output logic                  o_entry_valid,
    output logic                  o_last,
    output logic [CAP_W-1:0]      o_occupancy
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [IW-1:0] f_bump(input logic [IW-1:0] idx,
                                             input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] nx;
        nx = CAP_W'(idx) + CAP_W'(1);
        return (nx >= cap) ? '0 : nx[IW-1:0];
    endfunction

    function automatic logic [CAP_W-1:0] f_held(input logic empty, input logic full,
                                                input logic [IW-1:0] head,
                                                input logic [IW-1:0] tail,
                                                input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] cnt;
        if (empty) begin
            cnt = '0;
        end else if (full) begin
            cnt = cap;
        end else if (tail >= head) begin
            cnt = CAP_W'(tail) - CAP_W'(head);
        end else begin
            cnt = cap - CAP_W'(head) + CAP_W'(tail);
        end
        return cnt;
    endfunction

    t_state                r_state, n_state;
    logic [CAP_W-1:0]      r_cap, n_cap;
    logic [IW-1:0]         r_head, n_head;
    logic [IW-1:0]         r_tail, n_tail;
    logic                  r_full, n_full;
    logic                  r_empty, n_empty;
    logic [IW-1:0]         r_idx, n_idx;
    logic [CAP_W-1:0]      r_cnt, n_cnt;
    logic [CAP_W-1:0]      r_list_n, n_list_n;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_entry, n_out_entry;
    logic                  r_out_last, n_out_last;
    logic [CAP_W-1:0]      r_out_occ, n_out_occ;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  wr_en;
    logic                  rd_en;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [CAP_W-1:0]      cap_sat;
    logic [IW-1:0]         app_head;
    logic [IW-1:0]         app_tail;
    logic                  app_full;
    logic [IW-1:0]         rem_head;
    logic [CAP_W-1:0]      cur_held;
    logic                  list_go;

    always_comb begin
        priority if (i_cfg_wr_data == '0) begin
            cap_sat = CAP_W'(1);
        end else if (i_cfg_wr_data > CAP_W'(DEPTH)) begin
            cap_sat = CAP_W'(DEPTH);
        end else begin
            cap_sat = i_cfg_wr_data;
        end
    end

    assign app_head = r_full ? f_bump(r_head, r_cap) : r_head;
    assign app_tail = f_bump(r_tail, r_cap);
    assign app_full = r_full || (app_tail == app_head);
    assign rem_head = f_bump(r_head, r_cap);
    assign cur_held = f_held(r_empty, r_full, r_head, r_tail, r_cap);
    assign wr_data  = DATA_WIDTH'(i_cmd.value);

    assign o_cmd_pop = !i_cfg_wr_en && (r_state == ST_IDLE) && i_cmd_valid;
    assign list_go   = o_cmd_pop && (i_cmd.op == OP_LIST) && (cur_held != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (list_go) begin
                    n_state = ST_LIST;
                end
            end
            ST_LIST: begin
                if (r_cnt == CAP_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cap       = r_cap;
        n_head      = r_head;
        n_tail      = r_tail;
        n_full      = r_full;
        n_empty     = r_empty;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_list_n    = r_list_n;
        n_out_valid = 1'b0;
        n_out_entry = 1'b0;
        n_out_last  = 1'b0;
        n_out_occ   = r_out_occ;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        if (i_cfg_wr_en) begin
            n_cap   = cap_sat;
            n_head  = '0;
            n_tail  = '0;
            n_full  = 1'b0;
            n_empty = 1'b1;
        end else if (r_state == ST_LIST) begin
            rd_en       = 1'b1;
            n_out_valid = 1'b1;
            n_out_entry = 1'b1;
            n_out_last  = (r_cnt == CAP_W'(1));
            n_out_occ   = r_list_n;
            n_idx       = f_bump(r_idx, r_cap);
            n_cnt       = r_cnt - CAP_W'(1);
        end else if (o_cmd_pop) begin
            unique case (i_cmd.op)
                OP_APPEND: begin
                    wr_en       = 1'b1;
                    n_head      = app_head;
                    n_tail      = app_tail;
                    n_full      = app_full;
                    n_empty     = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_occ   = f_held(1'b0, app_full, app_head, app_tail, r_cap);
                end
                OP_REMOVE: begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_occ   = cur_held;
                    if (!r_empty) begin
                        if (rem_head == r_tail) begin
                            n_head    = '0;
                            n_tail    = '0;
                            n_full    = 1'b0;
                            n_empty   = 1'b1;
                            n_out_occ = '0;
                        end else begin
                            n_head    = rem_head;
                            n_full    = 1'b0;
                            n_out_occ = f_held(1'b0, 1'b0, rem_head, r_tail, r_cap);
                        end
                    end
                end
                OP_LIST: begin
                    if (cur_held == '0) begin
                        n_out_valid = 1'b1;
                        n_out_last  = 1'b1;
                        n_out_occ   = '0;
                    end else begin
                        n_idx    = r_head;
                        n_cnt    = cur_held;
                        n_list_n = cur_held;
                    end
                end
                OP_NOP: begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_occ   = cur_held;
                end
                default: begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    n_out_occ   = cur_held;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_W'(DEPTH);
            r_head      <= '0;
            r_tail      <= '0;
            r_full      <= 1'b0;
            r_empty     <= 1'b1;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_list_n    <= '0;
            r_out_valid <= 1'b0;
            r_out_entry <= 1'b0;
            r_out_last  <= 1'b0;
            r_out_occ   <= '0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_full      <= n_full;
            r_empty     <= n_empty;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_list_n    <= n_list_n;
            r_out_valid <= n_out_valid;
            r_out_entry <= n_out_entry;
            r_out_last  <= n_out_last;
            r_out_occ   <= n_out_occ;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_entry_valid  = r_out_entry;
    assign o_last         = r_out_last;
    assign o_occupancy    = r_out_occ;
    assign o_data         = r_out_entry ? OUT_W'(r_rd_data) : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/overwriting_ring_buffer.sv -----
//------------------------------------------------------------------------------
// overwriting_ring_buffer
// Ring buffer that overwrites its oldest entry when full, with append, remove
// and list commands.
//
// Channel   Direction  Handshake                      Payload
// command   in         start & !busy                  i_operation, i_value
// result    out        o_result_valid (one cycle)     o_data, o_entry_valid,
//                                                     o_last, o_occupancy
// config    in         i_cfg_wr_en                    i_cfg_wr_data
//
// Append, remove and unused codes are executed by the back end as it pops them,
// so such commands can be accepted every cycle while busy is low. A command is
// stored in the command queue and its result is registered in the back end. A
// list holds the back end while it reads each held entry from the entry memory;
// busy rises when the two-entry command queue is full. Synchronous reset leaves
// the buffer empty with capacity DEPTH. The receiver cannot stall results.
//------------------------------------------------------------------------------
`default_nettype none

module overwriting_ring_buffer
    import orb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OPC_W-1:0]   i_operation,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]   i_cfg_wr_data,
    output logic                    o_result_valid,
    output logic [OUT_W-1:0]        o_data,
    output logic                    o_entry_valid,
    output logic                    o_last,
    output logic [CAP_W-1:0]        o_occupancy
);

    logic q_full;
    logic q_valid;
    logic q_push;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    orb_front u_front (
        .start       (start),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_q_full    (q_full),
        .busy        (busy),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    orb_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (back_cmd)
    );

    orb_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd_valid    (q_valid),
        .i_cmd          (back_cmd),
        .o_cmd_pop      (q_pop),
        .o_result_valid (o_result_valid),
        .o_data         (o_data),
        .o_entry_valid  (o_entry_valid),
        .o_last         (o_last),
        .o_occupancy    (o_occupancy)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/orb_checker.sv -----
//------------------------------------------------------------------------------
// orb_checker
// Port-level assertions on the result channel of the ring buffer.
//------------------------------------------------------------------------------
`default_nettype none

module orb_checker
    import orb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_result_valid,
    input wire logic [OUT_W-1:0] o_data,
    input wire logic             o_entry_valid,
    input wire logic             o_last,
    input wire logic [CAP_W-1:0] o_occupancy
);

    a_status_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_entry_valid |-> o_data == '0)
        else $error("status beat carries nonzero data");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_entry_valid |-> o_last)
        else $error("status beat not marked last");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_occupancy <= CAP_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_entry_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_entry_valid |-> o_occupancy != '0)
        else $error("listed entry from an empty buffer");

    a_list_occ_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_entry_valid && !o_last |=>
            o_result_valid && o_entry_valid && $stable(o_occupancy))
        else $error("list read-out broken before its last beat");

endmodule

bind overwriting_ring_buffer orb_checker #(
    .DEPTH (DEPTH)
) u_orb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_result_valid (o_result_valid),
    .o_data         (o_data),
    .o_entry_valid  (o_entry_valid),
    .o_last         (o_last),
    .o_occupancy    (o_occupancy)
);

`default_nettype wire
